### hw/rtl/vrt_pkg.sv
// Voxel ray traversal: shared types and constants.
// Used by every file of the block; no dependencies.
package vrt_pkg;

	localparam int CELL_X_W  = 4;
	localparam int CELL_Y_W  = 6;
	localparam int CELL_Z_W  = 4;
	localparam int START_X_W = 21;
	localparam int START_Y_W = 23;
	localparam int START_Z_W = 21;
	localparam int RECIP_W   = 32;
	localparam int FACE_W    = 3;

	// widest internal coordinate (CHUNK_HEIGHT up to 256)
	localparam int COORD_W = 8;
	localparam int START_W = 23;
	localparam int Q_FRAC  = 16;
	localparam int DIFF_W  = 26;
	localparam int PROD_W  = DIFF_W + RECIP_W;
	localparam int T_W     = 32;
	localparam int N_AXES  = 3;

	localparam logic [T_W-1:0] T_MAX = 32'h7FFF_FFFF;
	localparam logic [T_W-1:0] T_MIN = 32'h8000_0000;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CAST  = 1'b1;

	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_CLOSE
	} ctrl_state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_data;
	} grid_ctl_t;

	typedef struct packed {
		logic                 issue;
		axis_t                axis;
		logic                 zero;
		logic [COORD_W-1:0]   coord;
		logic [START_W-1:0]   start;
		logic [RECIP_W-1:0]   recip;
	} setup_req_t;

	typedef struct packed {
		logic           valid;
		axis_t          axis;
		logic [T_W-1:0] t;
		logic [T_W-1:0] delta;
	} setup_res_t;

endpackage

### hw/rtl/vrt_ifs.sv
// Voxel ray traversal: request and result channel interfaces.
// Depends on vrt_pkg for field widths.
interface vrt_req_if;
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic [vrt_pkg::CELL_X_W-1:0]   cell_x;
	logic [vrt_pkg::CELL_Y_W-1:0]   cell_y;
	logic [vrt_pkg::CELL_Z_W-1:0]   cell_z;
	logic                           occupied;
	logic [vrt_pkg::START_X_W-1:0]  start_x;
	logic [vrt_pkg::START_Y_W-1:0]  start_y;
	logic [vrt_pkg::START_Z_W-1:0]  start_z;
	logic signed [vrt_pkg::RECIP_W-1:0] recip_x;
	logic signed [vrt_pkg::RECIP_W-1:0] recip_y;
	logic signed [vrt_pkg::RECIP_W-1:0] recip_z;
	logic [2:0]                     zero_axes;

	modport source (output valid, action, cell_x, cell_y, cell_z, occupied,
		start_x, start_y, start_z, recip_x, recip_y, recip_z, zero_axes,
		input ready);
	modport sink (input valid, action, cell_x, cell_y, cell_z, occupied,
		start_x, start_y, start_z, recip_x, recip_y, recip_z, zero_axes,
		output ready);
endinterface

interface vrt_res_if;
	logic                          valid;
	logic                          ready;
	logic                          has_hit;
	logic [vrt_pkg::CELL_X_W-1:0]  hit_x;
	logic [vrt_pkg::CELL_Y_W-1:0]  hit_y;
	logic [vrt_pkg::CELL_Z_W-1:0]  hit_z;
	logic [vrt_pkg::FACE_W-1:0]    entry_face;
	logic                          last;

	modport source (output valid, has_hit, hit_x, hit_y, hit_z, entry_face, last,
		input ready);
	modport sink (input valid, has_hit, hit_x, hit_y, hit_z, entry_face, last,
		output ready);
endinterface

### hw/rtl/vrt_grid.sv
// Voxel ray traversal: one-bit occupancy memory with a clearing sweep after reset.
// Single write port, one registered read port. Depends on vrt_pkg.
module vrt_grid #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vrt_pkg::grid_ctl_t ctl,
	input  logic [AW-1:0]      wr_addr,
	input  logic [AW-1:0]      rd_addr,
	output logic               rd_data,
	output logic               clear_busy
);

	logic          mem [DEPTH];
	logic          rd_data_q;
	logic          busy_q;
	logic [AW-1:0] clr_addr_q;
	logic [AW-1:0] waddr;
	logic          wdata;
	logic          wen;

	assign waddr = busy_q ? clr_addr_q : wr_addr;
	assign wdata = busy_q ? 1'b0 : ctl.wr_data;
	assign wen   = busy_q || ctl.wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data    = rd_data_q;
	assign clear_busy = busy_q;

endmodule

### hw/rtl/vrt_tsetup.sv
// Voxel ray traversal: per-axis start t and delta, one axis per cycle.
// Product registered, then floor shift and saturation. Depends on vrt_pkg.
module vrt_tsetup (
	input  logic                clk,
	input  logic                arst_n,
	input  vrt_pkg::setup_req_t req,
	output vrt_pkg::setup_res_t res
);

	localparam int BOUND_W = vrt_pkg::COORD_W + 1 + vrt_pkg::Q_FRAC;

	logic                                up;
	logic [BOUND_W-1:0]                  bound;
	logic signed [vrt_pkg::DIFF_W-1:0]   diff;
	logic signed [vrt_pkg::RECIP_W-1:0]  recip_s;
	logic signed [vrt_pkg::PROD_W-1:0]   prod_c;
	logic [vrt_pkg::T_W-1:0]             delta_c;

	logic                                valid_s1;
	vrt_pkg::axis_t                      axis_s1;
	logic                                zero_s1;
	logic signed [vrt_pkg::PROD_W-1:0]   prod_s1;
	logic [vrt_pkg::T_W-1:0]             delta_s1;

	logic signed [vrt_pkg::PROD_W-1:0]   sh;
	logic [vrt_pkg::T_W-1:0]             t_c;

	always_comb begin
		up      = !req.zero && !req.recip[vrt_pkg::RECIP_W-1];
		bound   = {({1'b0, req.coord} + (vrt_pkg::COORD_W + 1)'(up)),
			{vrt_pkg::Q_FRAC{1'b0}}};
		diff    = $signed(vrt_pkg::DIFF_W'(bound)) - $signed(vrt_pkg::DIFF_W'(req.start));
		recip_s = $signed(req.recip);
		prod_c  = diff * recip_s;
		if (req.zero) begin
			delta_c = '0;
		end else if (req.recip[vrt_pkg::RECIP_W-1]) begin
			delta_c = (req.recip == vrt_pkg::T_MIN) ? vrt_pkg::T_MAX : (~req.recip + 32'd1);
		end else begin
			delta_c = req.recip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (req.issue) begin
			axis_s1  <= req.axis;
			zero_s1  <= req.zero;
			prod_s1  <= prod_c;
			delta_s1 <= delta_c;
		end
	end

	// arithmetic shift is floor division by 2^16
	always_comb begin
		sh = prod_s1 >>> vrt_pkg::Q_FRAC;
		if (zero_s1) begin
			t_c = vrt_pkg::T_MAX;
		end else if ((&sh[vrt_pkg::PROD_W-1:vrt_pkg::T_W-1])
				|| !(|sh[vrt_pkg::PROD_W-1:vrt_pkg::T_W-1])) begin
			t_c = sh[vrt_pkg::T_W-1:0];
		end else begin
			t_c = sh[vrt_pkg::PROD_W-1] ? vrt_pkg::T_MIN : vrt_pkg::T_MAX;
		end
	end

	assign res.valid = valid_s1;
	assign res.axis  = axis_s1;
	assign res.t     = t_c;
	assign res.delta = delta_s1;

endmodule

### hw/rtl/vrt_ctrl.sv
// Voxel ray traversal: request intake, cast sequencer, DDA step and result register.
// Drives vrt_grid and vrt_tsetup. Depends on vrt_pkg and the channel interfaces.
module vrt_ctrl #(
	parameter int CHUNK_SIZE   = 16,
	parameter int CHUNK_HEIGHT = 64,
	parameter int MAX_STEPS    = 10,
	parameter int AW           = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	vrt_req_if.sink             req_ch,
	vrt_res_if.source           res_ch,
	output vrt_pkg::grid_ctl_t  grid_ctl,
	output logic [AW-1:0]       grid_wr_addr,
	output logic [AW-1:0]       grid_rd_addr,
	input  logic                grid_rd_data,
	input  logic                grid_busy,
	output vrt_pkg::setup_req_t sreq,
	input  vrt_pkg::setup_res_t sres
);

	localparam int CW = $clog2(CHUNK_SIZE);
	localparam int HW = $clog2(CHUNK_HEIGHT);
	localparam int SW = $clog2(MAX_STEPS + 1);

	function automatic logic [AW-1:0] cell_addr(input int x, input int y, input int z);
		return AW'((x * CHUNK_HEIGHT + y) * CHUNK_SIZE + z);
	endfunction

	vrt_pkg::ctrl_state_t state_q, state_d;

	logic [CW-1:0]                 cx_q, cz_q, nx, nz;
	logic [HW-1:0]                 cy_q, ny;
	logic [vrt_pkg::START_W-1:0]   st_q [vrt_pkg::N_AXES];
	logic [vrt_pkg::RECIP_W-1:0]   recip_q [vrt_pkg::N_AXES];
	logic [2:0]                    zero_q;
	logic [2:0]                    neg;
	logic signed [vrt_pkg::T_W-1:0] t_q [vrt_pkg::N_AXES];
	logic signed [vrt_pkg::T_W-1:0] d_q [vrt_pkg::N_AXES];
	logic [vrt_pkg::FACE_W-1:0]    face_q;
	logic [SW-1:0]                 steps_q;
	logic                          pend_q;
	logic [1:0]                    scnt_q;

	logic                          out_valid_q;
	logic                          has_hit_q, last_q;
	logic [vrt_pkg::CELL_X_W-1:0]  hit_x_q;
	logic [vrt_pkg::CELL_Y_W-1:0]  hit_y_q;
	logic [vrt_pkg::CELL_Z_W-1:0]  hit_z_q;
	logic [vrt_pkg::FACE_W-1:0]    out_face_q;

	logic                          fire, in_chunk, out_free, stop;
	logic                          setup_done, issue;
	logic                          stall, do_step, emit_hit, emit_close;
	vrt_pkg::axis_t                ax;
	logic [2:0]                    oob;
	logic                          oob_ax;
	logic signed [vrt_pkg::T_W:0]  tsum;
	logic signed [vrt_pkg::T_W-1:0] tsat;

	assign fire     = req_ch.valid && req_ch.ready;
	assign in_chunk = (int'(req_ch.cell_x) < CHUNK_SIZE) && (int'(req_ch.cell_y) < CHUNK_HEIGHT)
		&& (int'(req_ch.cell_z) < CHUNK_SIZE);
	assign out_free = !out_valid_q || res_ch.ready;
	assign setup_done = (scnt_q == 2'(vrt_pkg::N_AXES));

	// axis choice: ties to y over x, z over y
	always_comb begin
		neg = {recip_q[2][vrt_pkg::RECIP_W-1], recip_q[1][vrt_pkg::RECIP_W-1],
			recip_q[0][vrt_pkg::RECIP_W-1]} & ~zero_q;
		if (t_q[0] < t_q[1] && t_q[0] < t_q[2]) begin
			ax = vrt_pkg::AXIS_X;
		end else if (t_q[1] < t_q[2]) begin
			ax = vrt_pkg::AXIS_Y;
		end else begin
			ax = vrt_pkg::AXIS_Z;
		end
		oob[0] = !zero_q[0] && (neg[0] ? (cx_q == '0) : (cx_q == CW'(CHUNK_SIZE - 1)));
		oob[1] = !zero_q[1] && (neg[1] ? (cy_q == '0) : (cy_q == HW'(CHUNK_HEIGHT - 1)));
		oob[2] = !zero_q[2] && (neg[2] ? (cz_q == '0) : (cz_q == CW'(CHUNK_SIZE - 1)));
		nx = cx_q;
		ny = cy_q;
		nz = cz_q;
		case (ax)
			vrt_pkg::AXIS_X: begin
				oob_ax = oob[0];
				if (!zero_q[0]) nx = neg[0] ? cx_q - CW'(1) : cx_q + CW'(1);
			end
			vrt_pkg::AXIS_Y: begin
				oob_ax = oob[1];
				if (!zero_q[1]) ny = neg[1] ? cy_q - HW'(1) : cy_q + HW'(1);
			end
			vrt_pkg::AXIS_Z: begin
				oob_ax = oob[2];
				if (!zero_q[2]) nz = neg[2] ? cz_q - CW'(1) : cz_q + CW'(1);
			end
			default: begin
				oob_ax = 1'b1;
			end
		endcase
		tsum = {t_q[ax][vrt_pkg::T_W-1], t_q[ax]} + {d_q[ax][vrt_pkg::T_W-1], d_q[ax]};
		if (tsum[vrt_pkg::T_W] != tsum[vrt_pkg::T_W-1]) begin
			tsat = tsum[vrt_pkg::T_W] ? $signed(vrt_pkg::T_MIN) : $signed(vrt_pkg::T_MAX);
		end else begin
			tsat = tsum[vrt_pkg::T_W-1:0];
		end
		stop = (steps_q == SW'(MAX_STEPS)) || oob_ax;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			vrt_pkg::ST_IDLE: begin
				if (fire && req_ch.action == vrt_pkg::ACT_CAST) begin
					state_d = in_chunk ? vrt_pkg::ST_SETUP : vrt_pkg::ST_CLOSE;
				end
			end
			vrt_pkg::ST_SETUP: begin
				if (setup_done) state_d = vrt_pkg::ST_WALK;
			end
			vrt_pkg::ST_WALK: begin
				if (!stall && stop) state_d = vrt_pkg::ST_CLOSE;
			end
			vrt_pkg::ST_CLOSE: begin
				if (out_free) state_d = vrt_pkg::ST_IDLE;
			end
			default: begin
				state_d = vrt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ch.ready = 1'b0;
		issue        = 1'b0;
		stall        = 1'b0;
		do_step      = 1'b0;
		emit_hit     = 1'b0;
		emit_close   = 1'b0;
		case (state_q)
			vrt_pkg::ST_IDLE: begin
				req_ch.ready = !grid_busy;
			end
			vrt_pkg::ST_SETUP: begin
				issue = !setup_done;
			end
			vrt_pkg::ST_WALK: begin
				stall    = pend_q && grid_rd_data && !out_free;
				emit_hit = pend_q && grid_rd_data && out_free;
				do_step  = !stall && !stop;
			end
			vrt_pkg::ST_CLOSE: begin
				emit_close = out_free;
			end
			default: begin
			end
		endcase
	end

	assign grid_ctl.wr_en   = fire && req_ch.action == vrt_pkg::ACT_WRITE && in_chunk;
	assign grid_ctl.wr_data = req_ch.occupied;
	assign grid_ctl.rd_en   = do_step;
	assign grid_wr_addr     = cell_addr(int'(req_ch.cell_x), int'(req_ch.cell_y),
		int'(req_ch.cell_z));
	assign grid_rd_addr     = cell_addr(int'(nx), int'(ny), int'(nz));

	always_comb begin
		sreq.issue = issue;
		sreq.axis  = scnt_q;
		sreq.zero  = zero_q[0];
		sreq.coord = vrt_pkg::COORD_W'(cx_q);
		sreq.start = st_q[0];
		sreq.recip = recip_q[0];
		case (scnt_q)
			vrt_pkg::AXIS_Y: begin
				sreq.zero  = zero_q[1];
				sreq.coord = vrt_pkg::COORD_W'(cy_q);
				sreq.start = st_q[1];
				sreq.recip = recip_q[1];
			end
			vrt_pkg::AXIS_Z: begin
				sreq.zero  = zero_q[2];
				sreq.coord = vrt_pkg::COORD_W'(cz_q);
				sreq.start = st_q[2];
				sreq.recip = recip_q[2];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vrt_pkg::ST_IDLE;
			steps_q     <= '0;
			pend_q      <= 1'b0;
			scnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				steps_q <= '0;
				pend_q  <= 1'b0;
				scnt_q  <= '0;
			end
			if (issue) begin
				scnt_q <= scnt_q + 2'd1;
			end
			if (do_step) begin
				steps_q <= steps_q + SW'(1);
				pend_q  <= 1'b1;
			end else if (state_q == vrt_pkg::ST_WALK && !stall) begin
				pend_q <= 1'b0;
			end
			if (emit_hit || emit_close) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && req_ch.action == vrt_pkg::ACT_CAST) begin
			cx_q       <= CW'(req_ch.cell_x);
			cy_q       <= HW'(req_ch.cell_y);
			cz_q       <= CW'(req_ch.cell_z);
			st_q[0]    <= vrt_pkg::START_W'(req_ch.start_x);
			st_q[1]    <= req_ch.start_y;
			st_q[2]    <= vrt_pkg::START_W'(req_ch.start_z);
			recip_q[0] <= req_ch.recip_x;
			recip_q[1] <= req_ch.recip_y;
			recip_q[2] <= req_ch.recip_z;
			zero_q     <= req_ch.zero_axes;
		end
		if (sres.valid) begin
			t_q[sres.axis] <= $signed(sres.t);
			d_q[sres.axis] <= $signed(sres.delta);
		end
		if (do_step) begin
			cx_q    <= nx;
			cy_q    <= ny;
			cz_q    <= nz;
			t_q[ax] <= tsat;
			face_q  <= {ax, neg[ax]};
		end
		if (emit_hit) begin
			has_hit_q  <= 1'b1;
			hit_x_q    <= vrt_pkg::CELL_X_W'(cx_q);
			hit_y_q    <= vrt_pkg::CELL_Y_W'(cy_q);
			hit_z_q    <= vrt_pkg::CELL_Z_W'(cz_q);
			out_face_q <= face_q;
			last_q     <= 1'b0;
		end else if (emit_close) begin
			has_hit_q  <= 1'b0;
			hit_x_q    <= '0;
			hit_y_q    <= '0;
			hit_z_q    <= '0;
			out_face_q <= '0;
			last_q     <= 1'b1;
		end
	end

	assign res_ch.valid      = out_valid_q;
	assign res_ch.has_hit    = has_hit_q;
	assign res_ch.hit_x      = hit_x_q;
	assign res_ch.hit_y      = hit_y_q;
	assign res_ch.hit_z      = hit_z_q;
	assign res_ch.entry_face = out_face_q;
	assign res_ch.last       = last_q;

endmodule

### hw/rtl/voxel_ray_traversal_top.sv
// Voxel ray traversal top level: occupancy grid memory, t setup unit, cast sequencer.
// Depends on vrt_pkg, vrt_ifs, vrt_grid, vrt_tsetup and vrt_ctrl.
//
// req_ch (sink) takes requests: action 0 writes one grid cell, action 1 casts a ray
// from the given start cell. res_ch (source) returns, per cast, one item for every
// occupied cell entered (cell and entry face), then a closing item with last set.
// Writes return nothing; a write outside the chunk is dropped.
// After reset the grid is swept clear, one cell per cycle, with ready low.
// A cast is accepted, then t setup runs for each axis in turn through the one shared
// multiplier, then the DDA walk takes up to MAX_STEPS steps (each step is one grid
// read), the last read is checked, and the closing item is queued before the next
// request is taken. The grid read port sets the one-step-per-cycle pace while the walk
// is not held for the receiver.
// Results sit in a single output register. If the receiver stalls, the walk holds when
// it has a hit to report; ready returns once the closing item is queued, so the next
// request can be taken while that item waits.
module voxel_ray_traversal_top #(
	parameter int CHUNK_SIZE   = 16,
	parameter int CHUNK_HEIGHT = 64,
	parameter int MAX_STEPS    = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	vrt_req_if.sink   req_ch,
	vrt_res_if.source res_ch
);

	localparam int DEPTH = CHUNK_SIZE * CHUNK_HEIGHT * CHUNK_SIZE;
	localparam int AW    = $clog2(DEPTH);

	vrt_pkg::grid_ctl_t  grid_ctl;
	logic [AW-1:0]       grid_wr_addr;
	logic [AW-1:0]       grid_rd_addr;
	logic                grid_rd_data;
	logic                grid_busy;
	vrt_pkg::setup_req_t sreq;
	vrt_pkg::setup_res_t sres;

	vrt_grid #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_grid (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (grid_ctl),
		.wr_addr   (grid_wr_addr),
		.rd_addr   (grid_rd_addr),
		.rd_data   (grid_rd_data),
		.clear_busy(grid_busy)
	);

	vrt_tsetup u_tsetup (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (sreq),
		.res   (sres)
	);

	vrt_ctrl #(
		.CHUNK_SIZE  (CHUNK_SIZE),
		.CHUNK_HEIGHT(CHUNK_HEIGHT),
		.MAX_STEPS   (MAX_STEPS),
		.AW          (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_ch      (req_ch),
		.res_ch      (res_ch),
		.grid_ctl    (grid_ctl),
		.grid_wr_addr(grid_wr_addr),
		.grid_rd_addr(grid_rd_addr),
		.grid_rd_data(grid_rd_data),
		.grid_busy   (grid_busy),
		.sreq        (sreq),
		.sres        (sres)
	);

endmodule

### hw/rtl/vrt_checker.sv
// Voxel ray traversal: port-level checks over time, bound to the top level.
// Depends on vrt_pkg and voxel_ray_traversal_top.
module vrt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          req_action,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          res_has_hit,
	input logic [vrt_pkg::CELL_X_W-1:0]  res_hit_x,
	input logic [vrt_pkg::CELL_Y_W-1:0]  res_hit_y,
	input logic [vrt_pkg::CELL_Z_W-1:0]  res_hit_z,
	input logic [vrt_pkg::FACE_W-1:0]    res_entry_face,
	input logic                          res_last
);

	logic [1:0] open_q;
	logic       cast_in, close_out;

	assign cast_in   = req_valid && req_ready && req_action == vrt_pkg::ACT_CAST;
	assign close_out = res_valid && res_ready && res_last;

	// casts whose closing item is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (cast_in && !close_out) begin
			open_q <= open_q + 2'd1;
		end else if (close_out && !cast_in) begin
			open_q <= open_q - 2'd1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_close_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_last |-> !res_has_hit && res_hit_x == '0 && res_hit_y == '0
			&& res_hit_z == '0 && res_entry_face == '0)
		else $error("closing item carries hit data");

	a_cast_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cast_in |-> open_q <= 2'd1)
		else $error("cast taken while two casts are open");

	a_hit_in_cast: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_has_hit |-> open_q != 2'd0 && !res_last && res_entry_face <= 3'd5)
		else $error("hit outside a cast or with bad face");

endmodule

bind voxel_ray_traversal_top vrt_checker u_vrt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req_ch.valid),
	.req_ready     (req_ch.ready),
	.req_action    (req_ch.action),
	.res_valid     (res_ch.valid),
	.res_ready     (res_ch.ready),
	.res_has_hit   (res_ch.has_hit),
	.res_hit_x     (res_ch.hit_x),
	.res_hit_y     (res_ch.hit_y),
	.res_hit_z     (res_ch.hit_z),
	.res_entry_face(res_ch.entry_face),
	.res_last      (res_ch.last)
);
